/* hw/rtl/bale_pkg.sv */
// ============================================================================
// bale_pkg
// Shared sizes, codes and types of the bounded array list engine.
// ============================================================================
package bale_pkg;

  // Store geometry
  localparam int unsigned DEPTH      = 256;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Port field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 9;

  // Width for comparing an index against the element count
  localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Access to the element store: write port and read port
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic                  re;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  // One result as handed to the output register
  typedef struct packed {
    logic [VAL_W-1:0]    read_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

/* hw/rtl/bale_ram.sv */
// ============================================================================
// bale_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ============================================================================
module bale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data registered from the read address
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bale_ctrl.sv */
// ============================================================================
// bale_ctrl
// Request sequencer: decodes operations, keeps the element count, drives the
// element store and runs the shift-down loop of a remove.
// ============================================================================
module bale_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bale_pkg::OP_W-1:0]    op_i,
  input  logic [bale_pkg::IDX_W-1:0]   index_i,
  input  logic [bale_pkg::VAL_W-1:0]   value_i,
  output bale_pkg::mem_req_t           mem_o,
  input  logic [bale_pkg::ELEM_WIDTH-1:0] rdata_i,
  input  logic                         out_free_i,
  output logic                         push_o,
  output bale_pkg::res_t               res_o
);
  import bale_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic                  pend_q, pend_d;
  logic [ADDR_W-1:0]     paddr_q, paddr_d;
  logic [ELEM_WIDTH-1:0] rval_q, rval_d;
  status_e               rstat_q, rstat_d;

  logic idx_ok;
  logic full;

  assign idx_ok     = CMP_W'(index_i) < CMP_W'(cnt_q);
  assign full       = (cnt_q == CNT_W'(DEPTH));
  assign in_stall_o = (state_q != S_IDLE);

  // Sequence one request at a time
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    pend_d  = pend_q;
    paddr_d = paddr_q;
    rval_d  = rval_q;
    rstat_d = rstat_q;
    mem_o   = '0;
    push_o  = 1'b0;
    res_o   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          rval_d  = '0;
          rstat_d = ST_OK;
          state_d = S_DONE;
          unique case (op_e'(op_i))
            OP_APPEND: begin
              if (full) begin
                rstat_d = ST_FULL;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = cnt_q[ADDR_W-1:0];
                mem_o.wdata = ELEM_WIDTH'(value_i);
                cnt_d       = cnt_q + CNT_W'(1);
              end
            end
            OP_READ: begin
              if (!idx_ok) begin
                rstat_d = ST_RANGE;
              end else begin
                mem_o.re    = 1'b1;
                mem_o.raddr = ADDR_W'(index_i);
                state_d     = S_READ;
              end
            end
            OP_WRITE: begin
              if (!idx_ok) begin
                rstat_d = ST_RANGE;
              end else begin
                mem_o.we    = 1'b1;
                mem_o.waddr = ADDR_W'(index_i);
                mem_o.wdata = ELEM_WIDTH'(value_i);
              end
            end
            OP_REMOVE: begin
              if (!idx_ok) begin
                rstat_d = ST_RANGE;
              end else begin
                ptr_d   = CNT_W'(index_i) + CNT_W'(1);
                pend_d  = 1'b0;
                state_d = S_SHIFT;
              end
            end
            default: begin
              rstat_d = ST_RANGE;
            end
          endcase
        end
      end

      // Forward read data straight out, or hold it if the output is busy
      S_READ: begin
        if (out_free_i) begin
          push_o           = 1'b1;
          res_o.read_value = VAL_W'(rdata_i);
          res_o.status     = ST_OK;
          res_o.count      = COUNT_W'(cnt_q);
          state_d          = S_IDLE;
        end else begin
          rval_d  = rdata_i;
          rstat_d = ST_OK;
          state_d = S_DONE;
        end
      end

      // Read entry ptr while writing the previous one a place lower
      S_SHIFT: begin
        if (pend_q) begin
          mem_o.we    = 1'b1;
          mem_o.waddr = paddr_q;
          mem_o.wdata = rdata_i;
        end
        if (ptr_q < cnt_q) begin
          mem_o.re    = 1'b1;
          mem_o.raddr = ptr_q[ADDR_W-1:0];
          pend_d      = 1'b1;
          paddr_d     = ADDR_W'(ptr_q - CNT_W'(1));
          ptr_d       = ptr_q + CNT_W'(1);
        end else begin
          pend_d  = 1'b0;
          cnt_d   = cnt_q - CNT_W'(1);
          rval_d  = '0;
          rstat_d = ST_OK;
          state_d = S_DONE;
        end
      end

      // Hand the held result to the output register
      S_DONE: begin
        if (out_free_i) begin
          push_o           = 1'b1;
          res_o.read_value = VAL_W'(rval_q);
          res_o.status     = rstat_q;
          res_o.count      = COUNT_W'(cnt_q);
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    paddr_q <= paddr_d;
    rval_q  <= rval_d;
    rstat_q <= rstat_d;
  end

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> out_free_i)
    else $error("result pushed while output register busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (cnt_q == $past(cnt_q) + CNT_W'(1) ||
                         cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("element count moved by more than one");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.we && mem_o.re) |-> (mem_o.waddr != mem_o.raddr))
    else $error("store read and written at the same entry");

  a_shift_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == S_SHIFT && state_q == S_SHIFT))
    else $error("pending shift write outside the shift loop");
`endif

endmodule

/* hw/rtl/bounded_array_list_engine.sv */
// ============================================================================
// bounded_array_list_engine
// Ordered list of elements in a fixed store with append, read, write and
// shift-down remove.
// ============================================================================
// Takes one request at a time. Append, write, read and any failing request
// (list full, index out of range) pass through a read or done state before
// the result enters the output register, waiting while that register is busy.
// Remove first runs the shift-down loop: the store has one read and one
// write port, so the loop moves one element per cycle. The store holds no
// reset value and needs no clearing pass; the element count resets to zero.
// Results wait in an output register, and new requests are accepted meanwhile.
module bounded_array_list_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bale_pkg::OP_W-1:0]       op_i,
  input  logic [bale_pkg::IDX_W-1:0]      index_i,
  input  logic [bale_pkg::VAL_W-1:0]      value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bale_pkg::VAL_W-1:0]      read_value_o,
  output logic [bale_pkg::STATUS_W-1:0]   status_o,
  output logic [bale_pkg::COUNT_W-1:0]    count_o
);
  import bale_pkg::*;

  mem_req_t              mem;
  logic [ELEM_WIDTH-1:0] rdata;
  logic                  push;
  res_t                  res;
  logic                  out_free;
  logic                  out_valid_q, out_valid_d;
  res_t                  out_res_q;

  bale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .index_i    (index_i),
    .value_i    (value_i),
    .mem_o      (mem),
    .rdata_i    (rdata),
    .out_free_i (out_free),
    .push_o     (push),
    .res_o      (res)
  );

  bale_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH),
    .AW    (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  // Output register is free when empty or being drained this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_res_q.read_value;
  assign status_o     = out_res_q.status;
  assign count_o      = out_res_q.count;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the bounded array list engine: a scoreboard keeps
// its own copy of the list, predicts every response at request acceptance
// and compares it field by field against what the engine returns.
// ============================================================================
module tb;
  import bale_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1450;
  localparam int unsigned CYCLE_LIMIT  = 2_500_000;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 20;
  localparam int unsigned PRINT_CAP    = 40;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [OP_W-1:0]     op_i;
  logic [IDX_W-1:0]    index_i;
  logic [VAL_W-1:0]    value_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [VAL_W-1:0]    read_value_o;
  logic [STATUS_W-1:0] status_o;
  logic [COUNT_W-1:0]  count_o;

  // --------------------------------------------------------------------------
  // List scoreboard: mirrors the store and count, queues expected responses
  // --------------------------------------------------------------------------
  class list_scoreboard;
    logic [ELEM_WIDTH-1:0] elem_store [DEPTH];
    int unsigned           elem_count;
    res_t                  expected_q [$];
    int unsigned           error_count;
    int unsigned           results_seen;

    function new();
      elem_count   = 0;
      error_count  = 0;
      results_seen = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Apply one accepted request to the mirror and queue its response
    function res_t note_request(op_e op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
      res_t        want;
      int unsigned k;
      want = '0;
      want.status = ST_OK;
      if (op == OP_APPEND) begin
        if (elem_count >= DEPTH) begin
          want.status = ST_FULL;
        end else begin
          elem_store[elem_count] = val[ELEM_WIDTH-1:0];
          elem_count++;
        end
      end else if (idx >= elem_count) begin
        want.status = ST_RANGE;
      end else begin
        case (op)
          OP_READ: begin
            want.read_value = VAL_W'(elem_store[idx]);
          end
          OP_WRITE: begin
            elem_store[idx] = val[ELEM_WIDTH-1:0];
          end
          default: begin
            // shift later entries down over the removed one
            for (k = idx; k + 1 < elem_count; k++) begin
              elem_store[k] = elem_store[k+1];
            end
            elem_count--;
          end
        endcase
      end
      want.count = COUNT_W'(elem_count);
      expected_q.insert(expected_q.size(), want);
      return want;
    endfunction

    task report_mismatch(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
      if (error_count < PRINT_CAP) begin
        $display("[%0t] response %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, field, got, want);
      end
      error_count++;
    endtask

    // Compare one returned response against the oldest expectation
    task check_result(logic [VAL_W-1:0] rv, logic [STATUS_W-1:0] st,
                      logic [COUNT_W-1:0] cnt);
      res_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("response with none outstanding", rv, '0);
      end else begin
        want = expected_q.pop_front();
        if (rv !== want.read_value) report_mismatch("read_value", rv, want.read_value);
        if (st !== want.status)     report_mismatch("status", VAL_W'(st), VAL_W'(want.status));
        if (cnt !== want.count)     report_mismatch("count", VAL_W'(cnt), VAL_W'(want.count));
      end
    endtask
  endclass

  list_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned op_tally [4];
  int unsigned full_seen;
  int unsigned range_seen;
  int unsigned peak_count;
  int unsigned in_quiet_left;
  int unsigned stall_left;
  int unsigned stall_quiet_left;

  bounded_array_list_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles, %0d responses outstanding", CYCLE_LIMIT, sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // Check accepted responses and pick the next stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(read_value_o, status_o, count_o);
    end
    if (stall_left == 0 && stall_quiet_left == 0) begin
      case ($urandom_range(0, 99)) inside
        [0:59]:  stall_left = 0;
        [60:89]: stall_left = $urandom_range(1, 3);
        [90:96]: stall_left = $urandom_range(4, 12);
        [97:98]: stall_left = $urandom_range(20, 60);
        default: stall_quiet_left = $urandom_range(30, 120);
      endcase
    end
    if (stall_quiet_left > 0) begin
      stall_quiet_left--;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Gap after a request: mostly none or short, a few long, some quiet runs
  function automatic int unsigned next_in_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (in_quiet_left > 0) begin
      in_quiet_left--;
      next_in_gap = 0;
    end else if (r < 55) begin
      next_in_gap = 0;
    end else if (r < 85) begin
      next_in_gap = $urandom_range(1, 3);
    end else if (r < 95) begin
      next_in_gap = $urandom_range(4, 12);
    end else if (r < 98) begin
      next_in_gap = $urandom_range(20, 50);
    end else begin
      in_quiet_left = $urandom_range(30, 120);
      next_in_gap = 0;
    end
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       rand_value = '0;
      1:       rand_value = '1;
      default: rand_value = $urandom;
    endcase
  endfunction

  function automatic op_e pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25)      pick_op = OP_APPEND;
    else if (r < 55) pick_op = OP_READ;
    else if (r < 80) pick_op = OP_WRITE;
    else             pick_op = OP_REMOVE;
  endfunction

  // Mostly valid positions, with the ends favored; the rest mostly out of range or random
  function automatic logic [IDX_W-1:0] pick_index(int unsigned cnt);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cnt > 0 && r < 10) begin
      pick_index = IDX_W'(cnt - 1);
    end else if (cnt > 0 && r < 15) begin
      pick_index = '0;
    end else if (cnt > 0 && r < 80) begin
      pick_index = IDX_W'($urandom_range(0, cnt - 1));
    end else if (cnt < DEPTH && r < 90) begin
      pick_index = IDX_W'($urandom_range(cnt, DEPTH - 1));
    end else begin
      pick_index = IDX_W'($urandom_range(0, 255));
    end
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(op_e op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    res_t want;
    in_valid_i <= 1'b1;
    op_i       <= op;
    index_i    <= idx;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    want = sb.note_request(op, idx, val);
    items_sent++;
    op_tally[op]++;
    if (want.status == ST_FULL)  full_seen++;
    if (want.status == ST_RANGE) range_seen++;
    if (sb.elem_count > peak_count) peak_count = sb.elem_count;
  endtask

  // Drop valid for the given number of cycles, scrambling the idle payload
  task automatic pause_input(int unsigned cycles);
    if (cycles > 0) begin
      in_valid_i <= 1'b0;
      op_i       <= OP_W'($urandom_range(0, 3));
      index_i    <= IDX_W'($urandom);
      value_i    <= $urandom;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic issue(op_e op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    send_request(op, idx, val);
    pause_input(next_in_gap());
  endtask

  // Hold off new requests until every response is back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    int unsigned directed_sent;
    int unsigned episode;
    int unsigned mode;
    int unsigned target;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    op_i       = OP_APPEND;
    index_i    = '0;
    value_i    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range errors on an empty list, field extremes, shifts
    issue(OP_READ,   8'd0,   32'h1234_5678);
    issue(OP_WRITE,  8'd0,   32'hFFFF_FFFF);
    issue(OP_REMOVE, 8'd0,   32'h0);
    issue(OP_REMOVE, 8'd255, 32'hFFFF_FFFF);
    issue(OP_APPEND, 8'd255, 32'h0000_0000);
    issue(OP_APPEND, 8'd0,   32'hFFFF_FFFF);
    issue(OP_APPEND, 8'd170, 32'hA5A5_A5A5);
    issue(OP_READ,   8'd0,   32'h0);
    issue(OP_READ,   8'd1,   32'h0);
    issue(OP_READ,   8'd2,   32'h0);
    issue(OP_READ,   8'd3,   32'h0);
    issue(OP_WRITE,  8'd1,   32'h5A5A_5A5A);
    issue(OP_READ,   8'd1,   32'h0);
    issue(OP_REMOVE, 8'd0,   32'h0);
    issue(OP_READ,   8'd0,   32'h0);
    issue(OP_READ,   8'd1,   32'h0);
    issue(OP_REMOVE, 8'd1,   32'h0);
    issue(OP_READ,   8'd1,   32'h0);
    issue(OP_READ,   8'd0,   32'h0);
    issue(OP_REMOVE, 8'd0,   32'h0);
    issue(OP_READ,   8'd0,   32'h0);
    issue(OP_APPEND, 8'd85,  32'h0000_0001);
    wait_for_results();
    directed_sent = items_sent;

    // Random episodes: fill, drain or mixed traffic
    episode = 0;
    while (items_sent - directed_sent < RANDOM_ITEMS) begin
      mode = (episode == 0) ? 0 : $urandom_range(0, 9);
      if (mode <= 1) begin
        target = (episode == 0 || $urandom_range(0, 3) == 0) ? DEPTH
                 : $urandom_range(sb.elem_count, DEPTH);
        while (sb.elem_count < target && items_sent - directed_sent < RANDOM_ITEMS) begin
          issue(OP_APPEND, IDX_W'($urandom), rand_value());
        end
        if (sb.elem_count == DEPTH) begin
          // exercise the full list: refused appends, last slot, a remove at either end
          repeat ($urandom_range(1, 4)) issue(OP_APPEND, IDX_W'($urandom), rand_value());
          issue(OP_READ,  IDX_W'(DEPTH - 1), rand_value());
          issue(OP_WRITE, IDX_W'(DEPTH - 1), rand_value());
          issue(OP_READ,  IDX_W'(DEPTH - 1), rand_value());
          if ($urandom_range(0, 1) == 0) begin
            issue(OP_REMOVE, '0, rand_value());
          end else begin
            issue(OP_REMOVE, IDX_W'(DEPTH - 1), rand_value());
          end
          issue(OP_APPEND, IDX_W'($urandom), rand_value());
          issue(OP_APPEND, IDX_W'($urandom), rand_value());
        end
      end else if (mode <= 3) begin
        target = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, sb.elem_count / 2);
        while (sb.elem_count > target && items_sent - directed_sent < RANDOM_ITEMS) begin
          issue(OP_REMOVE, pick_index(sb.elem_count), rand_value());
        end
        if (sb.elem_count == 0) begin
          repeat ($urandom_range(1, 4)) issue(pick_op(), IDX_W'($urandom), rand_value());
        end
      end else begin
        repeat ($urandom_range(10, 60)) begin
          issue(pick_op(), pick_index(sb.elem_count), rand_value());
        end
      end
      if ($urandom_range(0, 4) == 0) wait_for_results();
      episode++;
    end

    // Let the last responses arrive, then watch for strays
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Summary: %0d requests (%0d append, %0d read, %0d write, %0d remove), %0d responses",
             items_sent, op_tally[OP_APPEND], op_tally[OP_READ], op_tally[OP_WRITE],
             op_tally[OP_REMOVE], sb.results_seen);
    $display("Summary: %0d list-full and %0d out-of-range responses, peak count %0d, %0d errors",
             full_seen, range_seen, peak_count, sb.error_count);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* bounded_array_list_engine.f */
hw/rtl/bale_pkg.sv
hw/rtl/bale_ram.sv
hw/rtl/bale_ctrl.sv
hw/rtl/bounded_array_list_engine.sv
tb/sv/tb.sv
